// ===== rtl/core/kprt_pkg.sv =====
// shared types and constants of the keepalive ping rtt tracker
package kprt_pkg;

   // ring depth of the moving average, a power of two
   localparam int AVG_DEPTH = 8;
   localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
   localparam int POS_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W     = 32 + AVG_SHIFT;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // reset values of the configuration registers
   localparam logic [15:0] PING_INTERVAL_RESET = 16'd1000;
   localparam logic [15:0] ABORT_TIMEOUT_RESET = 16'd2000;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PING_INTERVAL = 2'd0,
      CSR_ABORT_TIMEOUT = 2'd1
   } csr_index_type;

   // operation codes of an input transfer
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_POLL  = 2'd1,
      OP_PONG  = 2'd2,
      OP_NONE  = 2'd3
   } operation_type;

endpackage

// ===== rtl/core/keepalive_ping_rtt_tracker_core.sv =====
// keepalive ping engine with a ring-buffer moving average of the round-trip time
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_stall     | operation, now_ms, pong_sequence
//  rsp     | out       | rsp_valid / rsp_stall     | send_ping, ping_sequence, was_timeout,
//          |           |                           | sequence_mismatch, average_rtt_ms,
//          |           |                           | average_changed
//  csr     | in        | csr_write_enable          | csr_index, csr_write_data
//
// one transfer per cycle while rsp_stall is low; each request passes the execute stage
// and then the output register; the ring memory is read as the request is accepted, and
// the execute stage updates state and writes it back; reset clears control state at once;
// ring entries count as the first sample until the ring position wraps, so the ring memory
// needs no clearing pass; rsp_stall holds the output register and the execute stage, and
// reaches req_stall in the same cycle
module keepalive_ping_rtt_tracker_core
   import kprt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [31:0]            req_now_ms,
   input  logic [7:0]             req_pong_sequence,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_send_ping,
   output logic [7:0]             rsp_ping_sequence,
   output logic                   rsp_was_timeout,
   output logic                   rsp_sequence_mismatch,
   output logic [31:0]            rsp_average_rtt_ms,
   output logic                   rsp_average_changed,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic [15:0] interval_ff;
   logic [15:0] timeout_ff;

   // session state
   logic             awaiting_ff,  awaiting_in;
   logic [7:0]       seq_ff,       seq_in;
   logic [31:0]      sent_ff,      sent_in;
   logic [31:0]      pong_ff,      pong_in;
   logic             no_sample_ff, no_sample_in;
   logic             wrapped_ff,   wrapped_in;
   logic [POS_W-1:0] pos_ff,       pos_in;
   logic [SUM_W-1:0] sum_ff,       sum_in;
   logic [31:0]      avg_ff,       avg_in;
   logic [31:0]      first_rtt_ff, first_rtt_in;

   // execute stage
   logic          s1_valid_ff;
   operation_type s1_op_ff;
   logic [31:0]   s1_now_ff;
   logic [7:0]    s1_pseq_ff;

   // ring memory and its bypass
   logic [31:0]      ring_mem [AVG_DEPTH];
   logic [31:0]      ring_rd_ff;
   logic             byp_ff;
   logic [31:0]      byp_data_ff;
   logic             mem_wr_en;
   logic [31:0]      mem_wr_data;
   logic [POS_W-1:0] mem_rd_addr;

   // output register
   logic        rsp_valid_ff;
   logic        send_ff,     send_in;
   logic        timeout_flag_ff, timeout_flag_in;
   logic        mismatch_ff, mismatch_in;
   logic        changed_ff,  changed_in;

   logic        out_free;
   logic        advance;
   logic        req_accept;
   logic [31:0] rtt;
   logic [31:0] old_rtt;
   logic [31:0] since_sent;
   logic [31:0] since_pong;
   logic [POS_W-1:0] pos_next;

   // handshake control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // execute stage datapath
   assign since_sent = s1_now_ff - sent_ff;
   assign since_pong = s1_now_ff - pong_ff;
   assign rtt        = since_sent;
   assign old_rtt    = !wrapped_ff ? first_rtt_ff : (byp_ff ? byp_data_ff : ring_rd_ff);
   assign pos_next   = (pos_ff == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_ff + 1'b1;

   always_comb begin
      awaiting_in     = awaiting_ff;
      seq_in          = seq_ff;
      sent_in         = sent_ff;
      pong_in         = pong_ff;
      no_sample_in    = no_sample_ff;
      wrapped_in      = wrapped_ff;
      pos_in          = pos_ff;
      sum_in          = sum_ff;
      avg_in          = avg_ff;
      first_rtt_in    = first_rtt_ff;
      send_in         = 1'b0;
      timeout_flag_in = 1'b0;
      mismatch_in     = 1'b0;
      changed_in      = 1'b0;
      mem_wr_en       = 1'b0;
      mem_wr_data     = rtt;
      if (advance) begin
         unique case (s1_op_ff)
            OP_START: begin
               send_in = 1'b1;
            end
            OP_POLL: begin
               if (awaiting_ff) begin
                  if (since_sent > {16'd0, timeout_ff}) begin
                     send_in         = 1'b1;
                     timeout_flag_in = 1'b1;
                  end
               end else if (since_pong >= {16'd0, interval_ff}) begin
                  send_in = 1'b1;
               end
            end
            OP_PONG: begin
               if (s1_pseq_ff != seq_ff) begin
                  mismatch_in = 1'b1;
               end else begin
                  pong_in     = s1_now_ff;
                  awaiting_in = 1'b0;
                  if (no_sample_ff) begin
                     // first sample stands for every ring entry
                     no_sample_in = 1'b0;
                     first_rtt_in = rtt;
                     sum_in       = SUM_W'(rtt) * SUM_W'(AVG_DEPTH);
                  end else begin
                     sum_in    = sum_ff - SUM_W'(old_rtt) + SUM_W'(rtt);
                     mem_wr_en = 1'b1;
                     pos_in    = pos_next;
                     if (pos_ff == POS_W'(AVG_DEPTH - 1)) begin
                        wrapped_in = 1'b1;
                     end
                  end
                  avg_in     = 32'(sum_in >> AVG_SHIFT);
                  changed_in = (avg_in != avg_ff);
               end
            end
            default: begin
            end
         endcase
         if (send_in) begin
            seq_in      = seq_ff + 8'd1;
            sent_in     = s1_now_ff;
            awaiting_in = 1'b1;
         end
      end
   end

   // read address follows the position after the item in execute
   assign mem_rd_addr = pos_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= PING_INTERVAL_RESET;
         timeout_ff  <= ABORT_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_PING_INTERVAL) begin
            interval_ff <= csr_write_data;
         end else if (csr_index == CSR_ABORT_TIMEOUT) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   // session state
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         seq_ff       <= '0;
         sent_ff      <= '0;
         pong_ff      <= '0;
         no_sample_ff <= 1'b1;
         wrapped_ff   <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
      end else begin
         awaiting_ff  <= awaiting_in;
         seq_ff       <= seq_in;
         sent_ff      <= sent_in;
         pong_ff      <= pong_in;
         no_sample_ff <= no_sample_in;
         wrapped_ff   <= wrapped_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
      end
   end

   // first sample value, meaningful once no_sample_ff clears
   always_ff @(posedge clock) begin
      first_rtt_ff <= first_rtt_in;
   end

   // execute stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= operation_type'(req_operation);
         s1_now_ff  <= req_now_ms;
         s1_pseq_ff <= req_pong_sequence;
      end
   end

   // ring memory: write back from execute, read for the incoming transfer
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         ring_mem[pos_ff] <= mem_wr_data;
      end
      if (req_accept) begin
         ring_rd_ff <= ring_mem[mem_rd_addr];
      end
   end

   // bypass when the read hits the entry written in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (req_accept) begin
         byp_ff <= mem_wr_en && (pos_ff == mem_rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byp_data_ff <= mem_wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         send_ff         <= send_in;
         timeout_flag_ff <= timeout_flag_in;
         mismatch_ff     <= mismatch_in;
         changed_ff      <= changed_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_send_ping         = send_ff;
   assign rsp_ping_sequence     = seq_ff;
   assign rsp_was_timeout       = timeout_flag_ff;
   assign rsp_sequence_mismatch = mismatch_ff;
   assign rsp_average_rtt_ms    = avg_ff;
   assign rsp_average_changed   = changed_ff;

   // checks
   a_stall_only_when_busy : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall raised with an empty execute stage");

   a_seq_steps_on_send : assert property (@(posedge clock) disable iff (reset)
      (advance && send_in) |=> (seq_ff == $past(seq_ff) + 8'd1))
      else $error("sequence did not step on a sent ping");

   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(AVG_DEPTH - 1))
      else $error("ring position out of range");

   a_no_sample_clean : assert property (@(posedge clock) disable iff (reset)
      no_sample_ff |-> (!wrapped_ff && pos_ff == '0 && !mem_wr_en))
      else $error("ring touched before the first sample");

   a_bypass_after_write : assert property (@(posedge clock) disable iff (reset)
      $rose(byp_ff) |-> $past(mem_wr_en))
      else $error("bypass set without a ring write");

endmodule

// ===== bench/keepalive_ping_rtt_tracker_core_tb.sv =====
// self-checking testbench of the keepalive ping rtt tracker core
module keepalive_ping_rtt_tracker_core_tb
   import kprt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // register indexes that hold no register, writes to them are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HIGH = 2'd3;

   // one result transfer as the tracker should produce it
   typedef struct packed {
      bit        send_ping;
      bit [7:0]  ping_sequence;
      bit        was_timeout;
      bit        sequence_mismatch;
      bit [31:0] average_rtt_ms;
      bit        average_changed;
   } ping_result_type;

   // block inputs, all known from time zero
   logic                   clock                 = 1'b0;
   logic                   reset                 = 1'b1;
   logic                   req_valid             = 1'b0;
   operation_type          req_operation         = OP_NONE;
   logic [31:0]            req_now_ms            = '0;
   logic [7:0]             req_pong_sequence     = '0;
   logic                   rsp_stall             = 1'b0;
   logic                   csr_write_enable      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index             = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data        = '0;

   // block outputs
   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_send_ping;
   logic [7:0]             rsp_ping_sequence;
   logic                   rsp_was_timeout;
   logic                   rsp_sequence_mismatch;
   logic [31:0]            rsp_average_rtt_ms;
   logic                   rsp_average_changed;

   // predicted tracker state and its configuration
   bit [15:0]        interval_cfg       = PING_INTERVAL_RESET;
   bit [15:0]        timeout_cfg        = ABORT_TIMEOUT_RESET;
   bit               ping_awaiting      = 1'b0;
   bit [7:0]         ping_seq           = '0;
   bit [31:0]        ping_sent_ms       = '0;
   bit [31:0]        pong_seen_ms       = '0;
   bit               rtt_first_pending  = 1'b1;
   bit [31:0]        rtt_window [AVG_DEPTH];
   bit [POS_W-1:0]   rtt_slot           = '0;
   bit [SUM_W-1:0]   rtt_total          = '0;
   bit [31:0]        rtt_mean           = '0;

   // results still owed by the block, oldest first
   ping_result_type  pending_ping_results [$];

   // stimulus control shared by the tests and the receiver
   bit [31:0]        stim_ms            = '0;
   bit               req_idle_on        = 1'b1;
   bit               rsp_idle_on        = 1'b1;
   int               rsp_hold_cycles    = 0;
   int               error_count        = 0;

   keepalive_ping_rtt_tracker_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_now_ms            (req_now_ms),
      .req_pong_sequence     (req_pong_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_send_ping         (rsp_send_ping),
      .rsp_ping_sequence     (rsp_ping_sequence),
      .rsp_was_timeout       (rsp_was_timeout),
      .rsp_sequence_mismatch (rsp_sequence_mismatch),
      .rsp_average_rtt_ms    (rsp_average_rtt_ms),
      .rsp_average_changed   (rsp_average_changed),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #10 clock = ~clock;

   // idle cycles before a transfer, often none
   function automatic int draw_wait(bit enabled);
      if (!enabled || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   // a new ping goes out with the next sequence number
   function automatic void send_next_ping(bit [31:0] now);
      ping_seq      = ping_seq + 8'd1;
      ping_sent_ms  = now;
      ping_awaiting = 1'b1;
   endfunction

   // advance the predicted tracker by one request and return its result
   function automatic ping_result_type track_ping_step(operation_type op, bit [31:0] now,
                                                       bit [7:0] pong_seq);
      ping_result_type res;
      bit [31:0]       elapsed;
      bit [31:0]       new_mean;
      res = '0;
      unique case (op)
         OP_START: begin
            send_next_ping(now);
            res.send_ping = 1'b1;
         end
         OP_POLL: begin
            if (ping_awaiting) begin
               // resend once the pong is overdue
               elapsed = now - ping_sent_ms;
               if (elapsed > timeout_cfg) begin
                  send_next_ping(now);
                  res.send_ping   = 1'b1;
                  res.was_timeout = 1'b1;
               end
            end else begin
               elapsed = now - pong_seen_ms;
               if (elapsed >= interval_cfg) begin
                  send_next_ping(now);
                  res.send_ping = 1'b1;
               end
            end
         end
         OP_PONG: begin
            if (pong_seq != ping_seq) begin
               res.sequence_mismatch = 1'b1;
            end else begin
               elapsed       = now - ping_sent_ms;
               pong_seen_ms  = now;
               ping_awaiting = 1'b0;
               if (rtt_first_pending) begin
                  // first sample fills the whole window
                  rtt_first_pending = 1'b0;
                  rtt_total = '0;
                  for (int i = 0; i < AVG_DEPTH; i++) begin
                     rtt_window[i] = elapsed;
                     rtt_total     = rtt_total + SUM_W'(elapsed);
                  end
               end else begin
                  // later samples replace the oldest entry
                  rtt_total = rtt_total - SUM_W'(rtt_window[rtt_slot]) + SUM_W'(elapsed);
                  rtt_window[rtt_slot] = elapsed;
                  if (rtt_slot == POS_W'(AVG_DEPTH - 1)) rtt_slot = '0;
                  else rtt_slot = rtt_slot + 1'b1;
               end
               new_mean = 32'(rtt_total / SUM_W'(AVG_DEPTH));
               res.average_changed = (new_mean != rtt_mean);
               rtt_mean = new_mean;
            end
         end
         OP_NONE: ;
      endcase
      res.ping_sequence  = ping_seq;
      res.average_rtt_ms = rtt_mean;
      return res;
   endfunction

   // offer one request and wait for its transfer
   task automatic send_request(operation_type op, bit [31:0] now, bit [7:0] pong_seq);
      int gap;
      gap = draw_wait(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_now_ms        <= now;
      req_pong_sequence <= pong_seq;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_ping_results.push_back(track_ping_step(op, now, pong_seq));
   endtask

   // let the block run empty before touching its registers
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_ping_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, bit [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (index == CSR_PING_INTERVAL) interval_cfg = value;
      else if (index == CSR_ABORT_TIMEOUT) timeout_cfg = value;
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // special cases at reset configuration
   task automatic test_directed_cases();
      send_request(OP_PONG, 32'd0, 8'hFF);           // mismatched pong before start
      send_request(OP_PONG, 32'd7, 8'h00);           // pong before start with sequence 0
      send_request(OP_NONE, 32'hFFFF_FFFF, 8'hA5);
      send_request(OP_POLL, 32'd1006, 8'h00);        // one short of the interval
      send_request(OP_POLL, 32'd1007, 8'h00);        // interval reached
      send_request(OP_PONG, 32'd1040, 8'h01);
      send_request(OP_PONG, 32'd1050, 8'h01);        // repeated pong
      send_request(OP_START, 32'd2000, 8'h00);
      send_request(OP_START, 32'd2001, 8'h00);       // start while running
      send_request(OP_POLL, 32'd4001, 8'h00);        // exactly at the timeout
      send_request(OP_POLL, 32'd4002, 8'h00);        // past the timeout
      send_request(OP_PONG, 32'hFFFF_FFF0, 8'h04);   // huge round trip
      send_request(OP_PONG, 32'hFFFF_FFF1, 8'h03);   // stale sequence
      send_request(OP_START, 32'hFFFF_FFFF, 8'h00);
      send_request(OP_POLL, 32'h0000_07CF, 8'h00);   // exactly at the timeout across the time wrap
      send_request(OP_PONG, 32'h0000_0010, 8'h05);   // round trip across the wrap
      send_request(OP_POLL, 32'h0000_0010 + 32'd999, 8'h00);
      send_request(OP_POLL, 32'h0000_0010 + 32'd1000, 8'h00);
      send_request(OP_PONG, 32'h0000_0010 + 32'd1000, 8'h06);   // zero round trip
      send_request(OP_NONE, 32'd0, 8'h00);
      stim_ms = 32'h0000_0010 + 32'd1000;
   endtask

   // zero and full-scale registers, plus writes to unused indexes
   task automatic test_register_extremes();
      drain_results();
      write_register(CSR_PING_INTERVAL, 16'd0);
      write_register(CSR_ABORT_TIMEOUT, 16'd0);
      write_register(CSR_UNUSED_LOW, 16'hFFFF);
      write_register(CSR_UNUSED_HIGH, 16'hFFFF);
      send_request(OP_POLL, pong_seen_ms, 8'h00);          // zero interval sends at once
      send_request(OP_POLL, ping_sent_ms, 8'h00);          // same time, no resend
      send_request(OP_POLL, ping_sent_ms + 32'd1, 8'h00);  // any later poll resends
      send_request(OP_PONG, ping_sent_ms, ping_seq);
      drain_results();
      write_register(CSR_PING_INTERVAL, 16'hFFFF);
      write_register(CSR_ABORT_TIMEOUT, 16'hFFFF);
      send_request(OP_POLL, pong_seen_ms + 32'd65534, 8'h00);
      send_request(OP_POLL, pong_seen_ms + 32'd65535, 8'h00);
      send_request(OP_POLL, ping_sent_ms + 32'd65535, 8'h00);
      send_request(OP_POLL, ping_sent_ms + 32'd65536, 8'h00);
      send_request(OP_PONG, ping_sent_ms + 32'd3, ping_seq);
      stim_ms = pong_seen_ms;
   endtask

   // mostly starts, so the sequence wraps, while the receiver holds off
   task automatic test_sequence_wrap_under_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < 300; i++) begin
         if (i == 0 || i == 150) rsp_hold_cycles = 80;
         stim_ms = stim_ms + $urandom_range(0, 50);
         if (i % 8 == 7) send_request(OP_PONG, stim_ms, ping_seq);
         else send_request(OP_START, stim_ms, 8'($urandom));
      end
   endtask

   // ping and pong traffic around the configured intervals
   task automatic send_random_item();
      operation_type op;
      bit [7:0]      seq;
      int unsigned   span;
      int unsigned   pick;
      span = ((interval_cfg > timeout_cfg) ? interval_cfg : timeout_cfg) + 2;
      pick = $urandom_range(0, 99);
      // advance the stimulus time
      if (pick < 10) stim_ms = $urandom;
      else if (pick < 25 && ping_awaiting)
         stim_ms = ping_sent_ms + timeout_cfg + $urandom_range(0, 2) - 1;
      else if (pick < 25)
         stim_ms = pong_seen_ms + interval_cfg + $urandom_range(0, 2) - 1;
      else if (pick < 40) stim_ms = stim_ms + $urandom_range(0, 3);
      else stim_ms = stim_ms + $urandom_range(0, span);
      // pick the operation
      pick = $urandom_range(0, 99);
      seq  = 8'($urandom);
      if (pick < 8) op = OP_START;
      else if (pick < 13) op = OP_NONE;
      else if (pick < 55) op = OP_POLL;
      else begin
         op = OP_PONG;
         if (pick < 88) seq = ping_seq;
         else if (pick < 94) seq = ping_seq ^ (8'd1 << $urandom_range(0, 7));
      end
      send_request(op, stim_ms, seq);
   endtask

   task automatic test_random_traffic();
      bit [15:0] phase_interval;
      bit [15:0] phase_timeout;
      for (int p = 0; p < 6; p++) begin
         unique case (p)
            0: begin
               phase_interval = 16'd1;
               phase_timeout  = 16'd1;
            end
            1: begin
               phase_interval = 16'hFFFF;
               phase_timeout  = 16'hFFFF;
            end
            default: begin
               phase_interval = 16'($urandom_range(1, 300));
               phase_timeout  = 16'($urandom_range(1, 600));
            end
         endcase
         drain_results();
         write_register(CSR_PING_INTERVAL, phase_interval);
         write_register(CSR_ABORT_TIMEOUT, phase_timeout);
         req_idle_on = (p % 3 != 1);
         rsp_idle_on = (p % 3 != 2);
         for (int i = 0; i < 40; i++) send_random_item();
      end
   endtask

   // receiver: random stalls per transfer, or a long hold when asked
   initial begin : result_receiver
      int wait_cycles;
      forever begin
         if (rsp_hold_cycles > 0) begin
            wait_cycles     = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            wait_cycles = draw_wait(rsp_idle_on);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin : result_checker
      ping_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_ping_results.size() == 0) begin
            $error("unexpected result transfer: ping_sequence %0h", rsp_ping_sequence);
            error_count++;
         end else begin
            want = pending_ping_results.pop_front();
            compare_field("send_ping", 32'(want.send_ping), 32'(rsp_send_ping));
            compare_field("ping_sequence", 32'(want.ping_sequence),
                          32'(rsp_ping_sequence));
            compare_field("was_timeout", 32'(want.was_timeout), 32'(rsp_was_timeout));
            compare_field("sequence_mismatch", 32'(want.sequence_mismatch),
                          32'(rsp_sequence_mismatch));
            compare_field("average_rtt_ms", want.average_rtt_ms, rsp_average_rtt_ms);
            compare_field("average_changed", 32'(want.average_changed),
                          32'(rsp_average_changed));
         end
      end
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("keepalive_ping_rtt_tracker_core test failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_sequence_wrap_under_backpressure();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("keepalive_ping_rtt_tracker_core test passed");
      else $display("keepalive_ping_rtt_tracker_core test failed");
      $finish;
   end

endmodule
